/* rtl/gslt_pkg.sv */
// Package: shared types and constants of the serial gamepad port
package gslt_pkg;

  localparam int unsigned ButtonCount = 8;
  localparam int unsigned PatternW    = 64;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 64;

  localparam int unsigned LatchBit = 0;
  localparam int unsigned BitRight = 0;
  localparam int unsigned BitLeft  = 1;
  localparam int unsigned BitDown  = 2;
  localparam int unsigned BitUp    = 3;
  localparam int unsigned BitMsb   = ButtonCount - 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DPAD_FILTER   = 2'd0,
    CFG_TURBO_PATTERN = 2'd1
  } gslt_cfg_idx_e;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } gslt_op_e;

  typedef struct packed {
    gslt_op_e               opcode;
    logic [7:0]             write_value;
    logic [ButtonCount-1:0] normal_pressed;
    logic [ButtonCount-1:0] turbo_pressed;
  } gslt_req_t;

  typedef struct packed {
    logic read_bit;
  } gslt_rsp_t;

  typedef struct packed {
    logic latch;
    logic shift;
    logic filter_en;
  } gslt_merge_ctrl_t;

endpackage

/* rtl/gslt_stream_if.sv */
// Interface: valid/ready stream channel with a typed payload
interface gslt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/gslt_lane.sv */
// Button lane: resolves one button from normal and turbo state with its own pattern rotor
module gslt_lane
  import gslt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                latch_i,
  input  logic [PatternW-1:0] pattern_i,
  input  logic                normal_i,
  input  logic                turbo_i,
  output logic                value_o
);

  logic [PatternW-1:0] rotor_q, rotor_d, rotor_src;
  logic                phys_q, phys_d;

  assign rotor_src = phys_q ? rotor_q : pattern_i;

  always_comb begin
    rotor_d = rotor_q;
    phys_d  = phys_q;
    value_o = 1'b0;
    if (turbo_i) begin
      value_o = rotor_src[0];
      if (latch_i) begin
        rotor_d = {rotor_src[0], rotor_src[PatternW-1:1]};
        phys_d  = 1'b1;
      end
    end else if (normal_i) begin
      value_o = 1'b1;
      if (latch_i) begin
        phys_d = 1'b1;
      end
    end else if (latch_i) begin
      phys_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotor_q <= '0;
      phys_q  <= 1'b0;
    end else begin
      rotor_q <= rotor_d;
      phys_q  <= phys_d;
    end
  end

endmodule

/* rtl/gslt_merge.sv */
// Merge stage: d-pad filter over the lane results, status shift register and last report
module gslt_merge
  import gslt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gslt_merge_ctrl_t       ctrl_i,
  input  logic [ButtonCount-1:0] raw_i,
  output logic                   msb_o
);

  logic [ButtonCount-1:0] shift_q, shift_d;
  logic [ButtonCount-1:0] report_q, report_d;
  logic [ButtonCount-1:0] filtered;
  logic [1:0]             lr, ud;

  function automatic logic [1:0] filter_pair(logic a, logic c, logic pa, logic pc);
    logic [1:0] res;
    res = {a, c};
    if (!pa && a) begin
      res = {1'b1, 1'b0};
    end else if (!pc && c) begin
      res = {1'b0, 1'b1};
    end else if (a && c) begin
      res = 2'b00;
    end
    return res;
  endfunction

  assign lr = filter_pair(raw_i[BitLeft], raw_i[BitRight], report_q[BitLeft],
                          report_q[BitRight]);
  assign ud = filter_pair(raw_i[BitUp], raw_i[BitDown], report_q[BitUp], report_q[BitDown]);

  always_comb begin
    filtered = raw_i;
    if (ctrl_i.filter_en) begin
      filtered[BitLeft]  = lr[1];
      filtered[BitRight] = lr[0];
      filtered[BitUp]    = ud[1];
      filtered[BitDown]  = ud[0];
    end
  end

  always_comb begin
    shift_d  = shift_q;
    report_d = report_q;
    if (ctrl_i.latch) begin
      shift_d  = filtered;
      report_d = filtered;
    end else if (ctrl_i.shift) begin
      shift_d = {shift_q[ButtonCount-2:0], 1'b0};
    end
  end

  assign msb_o = shift_q[BitMsb];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= '0;
      report_q <= '0;
    end else begin
      shift_q  <= shift_d;
      report_q <= report_d;
    end
  end

endmodule

/* rtl/gamepad_serial_latch_turbo.sv */
// Top level: serial gamepad port with turbo lanes, d-pad filter and skid-buffered output
// Accepted results are registered in the output register, or in the skid when it stalls.
// Throughput: one access per cycle while the skid is empty; eight lanes latch in parallel.
// A two-entry output buffer (register plus skid) keeps input ready until the skid is full.
// Reset (asynchronous, active low) clears registers, shift state, lane rotors and empties buffers.
module gamepad_serial_latch_turbo
  import gslt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  gslt_stream_if.sink         req_if,
  gslt_stream_if.source       rsp_if
);

  logic                   filter_en_q;
  logic [PatternW-1:0]    pattern_q;
  logic                   acc;
  logic                   take;
  logic                   latch;
  logic [ButtonCount-1:0] raw;
  logic                   msb;
  gslt_merge_ctrl_t       mctrl;
  gslt_rsp_t              new_rsp;
  gslt_rsp_t              out_q, out_d, skid_q, skid_d;
  logic                   out_v_q, out_v_d, skid_v_q, skid_v_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_en_q <= 1'b0;
      pattern_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DPAD_FILTER:   filter_en_q <= cfg_wdata_i[0];
        CFG_TURBO_PATTERN: pattern_q   <= cfg_wdata_i[PatternW-1:0];
        default: ;
      endcase
    end
  end

  assign req_if.ready = !skid_v_q;
  assign acc          = req_if.valid && !skid_v_q;
  assign take         = out_v_q && rsp_if.ready;
  assign latch        = acc && (req_if.data.opcode == OP_WRITE) &&
                        req_if.data.write_value[LatchBit];

  for (genvar g = 0; g < ButtonCount; g++) begin : g_lane
    gslt_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .latch_i  (latch),
      .pattern_i(pattern_q),
      .normal_i (req_if.data.normal_pressed[g]),
      .turbo_i  (req_if.data.turbo_pressed[g]),
      .value_o  (raw[g])
    );
  end

  assign mctrl.latch     = latch;
  assign mctrl.shift     = acc && (req_if.data.opcode == OP_READ);
  assign mctrl.filter_en = filter_en_q;

  gslt_merge u_merge (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(mctrl),
    .raw_i (raw),
    .msb_o (msb)
  );

  assign new_rsp.read_bit = (req_if.data.opcode == OP_READ) ? msb : 1'b0;

  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (!out_v_q || take) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        out_d   = new_rsp;
        out_v_d = acc;
      end
    end else if (acc) begin
      skid_d   = new_rsp;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign rsp_if.valid = out_v_q;
  assign rsp_if.data  = out_q;

endmodule

/* rtl/gslt_checker.sv */
// Checker: port-level properties of the serial gamepad port, bound to the top level
module gslt_checker
  import gslt_pkg::*;
(
  input logic           clk_i,
  input logic           rst_ni,
  gslt_stream_if.sink   req_if,
  gslt_stream_if.source rsp_if
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_if.valid && !rsp_if.ready |=> rsp_if.valid)
    else $error("result dropped while stalled");

  a_stall_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_if.ready |-> rsp_if.valid)
    else $error("input stalled with no result pending");

  a_transfer_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_if.valid && req_if.ready |=> rsp_if.valid)
    else $error("accepted transfer produced no result");

  a_write_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_if.valid && req_if.ready && (req_if.data.opcode == OP_WRITE) && !rsp_if.valid
    |=> rsp_if.valid && (rsp_if.data.read_bit == 1'b0))
    else $error("write transfer returned a non-zero bit");

endmodule

bind gamepad_serial_latch_turbo gslt_checker u_gslt_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .req_if(req_if),
  .rsp_if(rsp_if)
);

/* sim/gamepad_serial_latch_turbo_tb.sv */
// Testbench: serial gamepad port checked against a cycle-free predictor under random handshakes
module gamepad_serial_latch_turbo_tb;
  import gslt_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;
  localparam logic [PatternW-1:0] PatAllOnes = '1;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  gslt_stream_if #(.T(gslt_req_t)) req_ch ();
  gslt_stream_if #(.T(gslt_rsp_t)) rsp_ch ();

  gamepad_serial_latch_turbo dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_if      (req_ch),
    .rsp_if      (rsp_ch)
  );

  bit          idle_on;
  int unsigned fault_count;
  logic        read_bits_due [$];

  logic                   filter_en;
  logic [PatternW-1:0]    turbo_pat;
  logic [ButtonCount-1:0] sh_reg;
  logic [ButtonCount-1:0] rep_bits;
  logic [ButtonCount-1:0] held_bits;
  logic [PatternW-1:0]    lane_rotor [ButtonCount];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [ButtonCount-1:0] cancel_pair(logic [ButtonCount-1:0] bits,
                                                         int unsigned first,
                                                         int unsigned second);
    logic a, c;
    a = bits[first];
    c = bits[second];
    if (!rep_bits[first] && a) begin
      c = 1'b0;
    end else if (!rep_bits[second] && c) begin
      a = 1'b0;
    end else if (a && c) begin
      a = 1'b0;
      c = 1'b0;
    end
    bits[first]  = a;
    bits[second] = c;
    return bits;
  endfunction

  function automatic void capture_buttons(logic [ButtonCount-1:0] normal,
                                          logic [ButtonCount-1:0] turbo);
    logic [ButtonCount-1:0] bits;
    bits = '0;
    for (int b = 0; b < ButtonCount; b++) begin
      if (turbo[b]) begin
        if (!held_bits[b]) lane_rotor[b] = turbo_pat;
        held_bits[b] = 1'b1;
        bits[b] = lane_rotor[b][0];
        lane_rotor[b] = {lane_rotor[b][0], lane_rotor[b][PatternW-1:1]};
      end else if (normal[b]) begin
        held_bits[b] = 1'b1;
        bits[b] = 1'b1;
      end else begin
        held_bits[b] = 1'b0;
      end
    end
    if (filter_en) begin
      bits = cancel_pair(bits, BitLeft, BitRight);
      bits = cancel_pair(bits, BitUp, BitDown);
    end
    sh_reg   = bits;
    rep_bits = bits;
  endfunction

  function automatic logic predict_access(gslt_req_t req);
    logic bit_out;
    bit_out = 1'b0;
    if (req.opcode == OP_READ) begin
      bit_out = sh_reg[BitMsb];
      sh_reg  = {sh_reg[ButtonCount-2:0], 1'b0};
    end else if (req.write_value[LatchBit]) begin
      capture_buttons(req.normal_pressed, req.turbo_pressed);
    end
    return bit_out;
  endfunction

  task automatic send_access(input gslt_req_t req);
    int unsigned gap;
    gap = (idle_on && $urandom_range(3) == 0) ? $urandom_range(4, 1) : 0;
    @(negedge clk);
    if (gap != 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.data  = req;
    req_ch.valid = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    read_bits_due = {read_bits_due, predict_access(req)};
  endtask

  task automatic do_read(input int unsigned count);
    gslt_req_t req;
    repeat (count) begin
      req.opcode         = OP_READ;
      req.write_value    = 8'($urandom);
      req.normal_pressed = 8'($urandom);
      req.turbo_pressed  = 8'($urandom);
      send_access(req);
    end
  endtask

  task automatic do_write(input logic [7:0] value, input logic [7:0] normal,
                          input logic [7:0] turbo);
    gslt_req_t req;
    req.opcode         = OP_WRITE;
    req.write_value    = value;
    req.normal_pressed = normal;
    req.turbo_pressed  = turbo;
    send_access(req);
  endtask

  task automatic drain;
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (read_bits_due.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic program_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_DPAD_FILTER:   filter_en = data[0];
      CFG_TURBO_PATTERN: turbo_pat = data;
      default: ;
    endcase
  endtask

  task automatic test_port_basics;
    do_read(1);
    do_write(8'hFE, 8'hFF, 8'hFF);
    do_read(1);
    do_write(8'h01, 8'hFF, 8'h00);
    do_read(9);
    do_write(8'hFF, 8'h00, 8'h80);
    do_read(1);
    drain();
  endtask

  task automatic test_turbo_and_filter;
    program_reg(CFG_TURBO_PATTERN, PatAllOnes);
    program_reg(CFG_DPAD_FILTER, 64'h1);
    program_reg(CfgSpareLo, 64'h0);
    program_reg(CfgSpareHi, PatAllOnes);
    do_write(8'h01, 8'h00, 8'h80);
    do_read(1);
    do_write(8'h01, 8'h0F, 8'h00);
    do_read(5);
    do_write(8'h01, 8'h0F, 8'h00);
    do_read(8);
    do_write(8'h01, 8'hFF, 8'hFF);
    do_read(2);
    drain();
  endtask

  task automatic test_random_traffic(input logic filter, input logic [PatternW-1:0] pattern,
                                     input int unsigned count, input bit with_idle);
    int unsigned sent;
    int unsigned kind;
    int unsigned reads;
    logic [7:0]  normal;
    logic [7:0]  turbo;
    program_reg(CFG_DPAD_FILTER, {63'($urandom), filter});
    program_reg(CFG_TURBO_PATTERN, pattern);
    idle_on = with_idle;
    sent    = 0;
    normal  = 8'($urandom);
    turbo   = '0;
    while (sent < count) begin
      kind = $urandom_range(9);
      if (kind <= 6) begin
        if ($urandom_range(1) == 0) begin
          normal = 8'($urandom);
          turbo  = ($urandom_range(1) == 0) ? 8'($urandom) & 8'($urandom) : 8'h00;
        end else if ($urandom_range(1) == 0) begin
          normal[$urandom_range(7)] = ~normal[$urandom_range(7)];
          turbo[$urandom_range(7)]  = ~turbo[$urandom_range(7)];
        end
        do_write({7'($urandom), 1'b1}, normal, turbo);
        reads = ($urandom_range(3) == 0) ? $urandom_range(12) : 8;
        do_read(reads);
        sent += 1 + reads;
      end else if (kind == 7) begin
        do_write({7'($urandom), 1'b0}, 8'($urandom), 8'($urandom));
        sent++;
      end else begin
        reads = $urandom_range(3, 1);
        do_read(reads);
        sent += reads;
      end
    end
    drain();
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(3) == 0) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(4, 1)) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
    end
  end

  initial begin
    logic due;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
        if (read_bits_due.size() == 0) begin
          $error("read_bit: expected none, got %0b", rsp_ch.data.read_bit);
          fault_count++;
        end else begin
          due = read_bits_due.pop_front();
          if (due !== rsp_ch.data.read_bit) begin
            $error("read_bit: expected %0b, got %0b", due, rsp_ch.data.read_bit);
            fault_count++;
          end
        end
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    idle_on      = 1'b1;
    fault_count  = 0;
    filter_en    = 1'b0;
    turbo_pat    = '0;
    sh_reg       = '0;
    rep_bits     = '0;
    held_bits    = '0;
    for (int b = 0; b < ButtonCount; b++) lane_rotor[b] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_port_basics();
    test_turbo_and_filter();
    test_random_traffic(1'b0, PatAllOnes, 160, 1'b1);
    test_random_traffic(1'b1, {$urandom, $urandom}, 160, 1'b1);
    test_random_traffic(1'b1, '0, 160, 1'b1);
    test_random_traffic(1'b0, 64'h8000_0000_0000_0001, 160, 1'b1);
    test_random_traffic(1'b1, {$urandom, $urandom}, 160, 1'b0);

    repeat (4) @(posedge clk);
    if (fault_count == 0 && read_bits_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/gslt_pkg.sv
rtl/gslt_stream_if.sv
rtl/gslt_lane.sv
rtl/gslt_merge.sv
rtl/gamepad_serial_latch_turbo.sv
rtl/gslt_checker.sv
sim/gamepad_serial_latch_turbo_tb.sv
